/* rtl/fdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_pkg
// Shared sizes and codes for the descriptor table.
// ----------------------------------------------------------------------------
package fdt_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // The free-slot search looks at this many slots per cycle.
  localparam int GROUP   = 4;
  localparam int NGROUP  = (SLOTS + GROUP - 1) / GROUP;
  localparam int GRP_W   = (NGROUP > 1) ? $clog2(NGROUP) : 1;
  localparam int CAND_W  = GRP_W + 2;

  // Index and count widths used when moving to and from the fixed port fields.
  localparam int IDX_EXT_W = (SLOT_W > 4) ? SLOT_W : 4;
  localparam int CNT_EXT_W = (CNT_W > 5) ? CNT_W : 5;

  // Stored entry: offset, flags, global id (global id in the low bits).
  localparam int ENTRY_W = 64;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 32;

  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [CNT_W-1:0]  cnt_t;

endpackage

/* rtl/fdt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fdt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/file_descriptor_table_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// file_descriptor_table_top
// Descriptor table with open, set and close operations and a live count.
// ----------------------------------------------------------------------------
// Each accepted word is one operation and yields exactly one result word. The
// block takes one operation at a time: after acceptance the sequencer goes
// from idle to an execute state and then to a done state, which loads the
// result register once the output is free. An open of the lowest free slot
// passes through a scan state between the two, which looks at four slots of
// the active map each cycle until it finds a free one or has seen the last
// group. The stored fields sit in a RAM with one write and one registered
// read port. A new word is accepted as soon as the sequencer is back in idle,
// even while the last result still waits on the output. The active map lives
// in flip-flops and is cleared by reset; the stored fields are undefined until
// a set writes them, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module file_descriptor_table_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // pick_specific[0], slot_index[4:1], global_id[20:5], file_flags[36:21],
  // rw_offset[68:37], zero fill above
  input  logic [fdt_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode[1:0]
  input  logic [1:0]                       in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], slot_out[5:2], global_id_out[21:6], live_count[26:22],
  // zero fill above
  output logic [fdt_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fdt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [GRP_W-1:0] grp_r, grp_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;
  cnt_t             cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Latched operation.
  logic [1:0]  op_r;
  logic        spec_r;
  logic [3:0]  idx_r;
  logic [15:0] gid_r;
  logic [15:0] flg_r;
  logic [31:0] off_r;

  // Result being built.
  logic [1:0] status_r, status_nxt;
  slot_t      slot_r, slot_nxt;
  logic       ret_gid_r, ret_gid_nxt;

  // Output register.
  logic [1:0]  out_status_r;
  logic [3:0]  out_slot_r;
  logic [15:0] out_gid_r;
  logic [4:0]  out_cnt_r;

  logic                 in_accept;
  logic [IDX_EXT_W-1:0] idx_ext;
  slot_t                addr;
  logic                 in_range;
  logic                 slot_active;
  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_rdata;

  logic [NGROUP*GROUP-1:0] free_vec;
  logic [GROUP-1:0]        grp_free;
  logic [1:0]              lo_sel;
  logic                    any_free;
  logic [CAND_W-1:0]       cand;
  logic [IDX_EXT_W-1:0]    slot_ext;
  logic [CNT_EXT_W-1:0]    cnt_ext;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  assign idx_ext     = IDX_EXT_W'(idx_r);
  assign addr        = idx_ext[SLOT_W-1:0];
  assign in_range    = ({1'b0, idx_ext} < (IDX_EXT_W + 1)'(SLOTS));
  assign slot_active = in_range && active_r[addr];

  // Slots past the end of the table are padded as busy.
  always_comb begin
    free_vec              = '0;
    free_vec[SLOTS-1:0]   = ~active_r;
  end

  assign grp_free = free_vec[grp_r*GROUP +: GROUP];

  always_comb begin
    any_free = 1'b0;
    lo_sel   = 2'd0;
    for (int i = GROUP - 1; i >= 0; i--) begin
      if (grp_free[i]) begin
        any_free = 1'b1;
        lo_sel   = 2'(i);
      end
    end
  end

  assign cand = {grp_r, lo_sel};

  always_comb begin
    state_nxt     = state_r;
    grp_nxt       = grp_r;
    active_nxt    = active_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    ret_gid_nxt   = ret_gid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ram_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt  = ST_OK;
        slot_nxt    = addr;
        ret_gid_nxt = 1'b0;
        grp_nxt     = '0;
        state_nxt   = S_DONE;
        case (op_r)
          OP_OPEN: begin
            if (!spec_r) begin
              state_nxt = S_SCAN;
            end else if (!in_range) begin
              status_nxt = ST_FULL;
            end else if (!active_r[addr]) begin
              active_nxt[addr] = 1'b1;
              cnt_nxt          = cnt_r + cnt_t'(1);
            end
          end
          OP_SET: begin
            if (slot_active) begin
              ram_we = 1'b1;
            end else begin
              status_nxt = ST_INACTIVE;
            end
          end
          OP_CLOSE: begin
            if (slot_active) begin
              active_nxt[addr] = 1'b0;
              cnt_nxt          = cnt_r - cnt_t'(1);
              ret_gid_nxt      = 1'b1;
            end else begin
              status_nxt = ST_INACTIVE;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (any_free) begin
          active_nxt[cand[SLOT_W-1:0]] = 1'b1;
          cnt_nxt   = cnt_r + cnt_t'(1);
          slot_nxt  = cand[SLOT_W-1:0];
          state_nxt = S_DONE;
        end else if (grp_r == GRP_W'(NGROUP - 1)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          grp_nxt = grp_r + GRP_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= '0;
      active_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grp_r       <= grp_nxt;
      active_r    <= active_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign slot_ext = IDX_EXT_W'(slot_r);
  assign cnt_ext  = CNT_EXT_W'(cnt_r);

  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    slot_r    <= slot_nxt;
    ret_gid_r <= ret_gid_nxt;
    if (in_accept) begin
      op_r   <= in_tuser;
      spec_r <= in_tdata[0];
      idx_r  <= in_tdata[4:1];
      gid_r  <= in_tdata[20:5];
      flg_r  <= in_tdata[36:21];
      off_r  <= in_tdata[68:37];
    end
    if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_ext[3:0];
      // The read port follows the latched slot, so its data is settled here.
      out_gid_r    <= ret_gid_r ? ram_rdata[15:0] : 16'd0;
      out_cnt_r    <= cnt_ext[4:0];
    end
  end

  fdt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata ({off_r, flg_r, gid_r}),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_cnt_r, out_gid_r, out_slot_r, out_status_r};

  // The live count always matches the number of active slots.
  a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
    ({{(32 - CNT_W){1'b0}}, cnt_r} == 32'($countones(active_r))))
    else $error("live count does not match the active map");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cnt_r} <= (CNT_W + 1)'(SLOTS)))
    else $error("live count above table size");

  a_scan_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (op_r == OP_OPEN && !spec_r))
    else $error("free-slot scan outside an open of the lowest free slot");

  a_scan_ends_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && !any_free && grp_r == GRP_W'(NGROUP - 1))
      |-> (active_r == {SLOTS{1'b1}}))
    else $error("table reported full while a slot is free");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the descriptor table.
// ----------------------------------------------------------------------------
// Open, set and close words go in on the input stream and are predicted one
// by one against a local copy of the table. Each predicted result waits in a
// queue until the matching output word arrives, and is then checked field by
// field. A few directed cases come first: the unused opcode, inactive slots, a
// table filled to the full condition, and set and close at the edge slots and
// field values. Random traffic follows, swinging between fill-heavy and
// drain-heavy stretches so that both the empty and the full table are reached.
// Both stream sides stall at random, at rates that change between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import fdt_pkg::*;

  localparam int         CLK_PERIOD  = 12;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] OP_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        pick;
    logic [3:0]  idx;
    logic [15:0] gid;
    logic [15:0] flags;
    logic [31:0] offset;
  } table_op_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [15:0] gid;
    logic [4:0]  count;
  } table_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic [1:0]              in_tuser = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // Local copy of the table.
  bit [SLOTS-1:0] slot_live;
  logic [15:0]    slot_gid [SLOTS];
  logic [15:0]    slot_flags [SLOTS];
  logic [31:0]    slot_offset [SLOTS];
  int             live_total;

  // Slots whose global id has been written since reset; only these may be closed.
  bit [SLOTS-1:0] gid_known;

  table_result_t  awaited_results [$];
  table_result_t  head_result;
  int             mismatch_count;
  int             cycle_count;
  int             tx_idle_pct;
  int             rx_idle_pct;

  file_descriptor_table_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    mismatch_count++;
  endtask

  function automatic table_result_t apply_table_op(input table_op_t op);
    table_result_t res;
    bit            found;
    bit            in_range;
    res.status = ST_OK;
    res.slot   = op.idx;
    res.gid    = '0;
    in_range   = (int'(op.idx) < SLOTS);
    case (op.opcode)
      OP_OPEN: begin
        if (op.pick) begin
          if (!in_range) begin
            res.status = ST_FULL;
          end else if (!slot_live[op.idx]) begin
            slot_live[op.idx] = 1'b1;
            live_total++;
          end
        end else begin
          found = 1'b0;
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && !slot_live[i]) begin
              slot_live[i] = 1'b1;
              live_total++;
              res.slot = 4'(i);
              found = 1'b1;
            end
          end
          if (!found) res.status = ST_FULL;
        end
      end
      OP_SET: begin
        if (in_range && slot_live[op.idx]) begin
          slot_gid[op.idx]    = op.gid;
          slot_flags[op.idx]  = op.flags;
          slot_offset[op.idx] = op.offset;
        end else begin
          res.status = ST_INACTIVE;
        end
      end
      OP_CLOSE: begin
        if (in_range && slot_live[op.idx]) begin
          slot_live[op.idx] = 1'b0;
          if (live_total > 0) live_total--;
          res.gid = slot_gid[op.idx];
        end else begin
          res.status = ST_INACTIVE;
        end
      end
      default: ;
    endcase
    res.count = 5'(live_total);
    return res;
  endfunction

  function automatic table_op_t make_op(input logic [1:0] opcode, input logic pick,
                                        input logic [3:0] idx, input logic [15:0] gid,
                                        input logic [15:0] flags,
                                        input logic [31:0] offset);
    table_op_t op;
    op.opcode = opcode;
    op.pick   = pick;
    op.idx    = idx;
    op.gid    = gid;
    op.flags  = flags;
    op.offset = offset;
    return op;
  endfunction

  // Holds the word on the bus until it is taken, then predicts its result.
  // tvalid stays high after acceptance; the next call lowers it or puts its own word in place, and the end lowers it.
  task automatic send_table_op(input table_op_t op);
    table_result_t want;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op.opcode;
    in_tdata  <= {3'b000, op.offset, op.flags, op.gid, op.idx, op.pick};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = apply_table_op(op);
    if (op.opcode == OP_SET && want.status == ST_OK) gid_known[op.idx] = 1'b1;
    awaited_results.push_back(want);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result word", '0, out_tdata);
      end else begin
        head_result = awaited_results.pop_front();
        if (out_tdata[1:0] !== head_result.status)
          report_mismatch("status", head_result.status, out_tdata[1:0]);
        if (out_tdata[5:2] !== head_result.slot)
          report_mismatch("slot_out", head_result.slot, out_tdata[5:2]);
        if (out_tdata[21:6] !== head_result.gid)
          report_mismatch("global_id_out", head_result.gid, out_tdata[21:6]);
        if (out_tdata[26:22] !== head_result.count)
          report_mismatch("live_count", head_result.count, out_tdata[26:22]);
        if (out_tdata[OUT_TDATA_W-1:27] !== '0)
          report_mismatch("zero fill", '0, out_tdata[OUT_TDATA_W-1:27]);
      end
    end
  end

  task automatic set_idling(input int tx_pct, input int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
  endtask

  task automatic test_ignored_opcode();
    send_table_op(make_op(OP_UNUSED, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_inactive_slot();
    send_table_op(make_op(OP_CLOSE, 1'b0, 4'h0, 16'h0000, 16'h0000, 32'h0));
    send_table_op(make_op(OP_SET, 1'b1, 4'hF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
  endtask

  // The named open of the top slot comes first, so the lowest-free search
  // must skip it at the end of the fill.
  task automatic test_fill_to_full();
    send_table_op(make_op(OP_OPEN, 1'b1, 4'hF, 16'h0, 16'h0, 32'h0));
    for (int i = 0; i < SLOTS - 1; i++) begin
      send_table_op(make_op(OP_OPEN, 1'b0, 4'(SLOTS - 1 - i), 16'h0, 16'h0, 32'h0));
    end
    send_table_op(make_op(OP_OPEN, 1'b0, 4'h9, 16'h0, 16'h0, 32'h0));
    send_table_op(make_op(OP_OPEN, 1'b1, 4'h7, 16'h0, 16'h0, 32'h0));
  endtask

  task automatic test_set_and_close();
    send_table_op(make_op(OP_SET, 1'b0, 4'h0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_table_op(make_op(OP_SET, 1'b1, 4'hF, 16'h0000, 16'h0000, 32'h0));
    send_table_op(make_op(OP_CLOSE, 1'b1, 4'h0, 16'h0, 16'h0, 32'h0));
    send_table_op(make_op(OP_CLOSE, 1'b0, 4'hF, 16'h0, 16'h0, 32'h0));
    send_table_op(make_op(OP_CLOSE, 1'b0, 4'h0, 16'h0, 16'h0, 32'h0));
  endtask

  // Stretches of forty counted words (unused opcodes apart) lean toward filling,
  // draining or neither, so the live count sweeps across its whole range.
  task automatic test_random_traffic(input int n_ops);
    table_op_t op;
    int        done;
    int        stretch;
    int        open_pct;
    int        set_pct;
    int        roll;
    int        live_slots [$];
    done    = 0;
    stretch = 0;
    while (done < n_ops) begin
      if (stretch == 0) begin
        stretch = 40;
        case ($urandom_range(0, 2))
          0:       begin open_pct = 65; set_pct = 20; end
          1:       begin open_pct = 15; set_pct = 20; end
          default: begin open_pct = 35; set_pct = 30; end
        endcase
      end
      op.pick   = 1'($urandom_range(0, 1));
      op.idx    = 4'($urandom_range(0, SLOTS - 1));
      op.gid    = 16'($urandom);
      op.flags  = 16'($urandom);
      op.offset = 32'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        op.opcode = OP_UNUSED;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < open_pct) op.opcode = OP_OPEN;
        else if (roll < open_pct + set_pct) op.opcode = OP_SET;
        else op.opcode = OP_CLOSE;
      end
      if (op.opcode == OP_SET || op.opcode == OP_CLOSE) begin
        live_slots.delete();
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) live_slots.push_back(i);
        end
        if (live_slots.size() != 0 && $urandom_range(0, 99) < 85)
          op.idx = 4'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
      end
      // A slot whose id was never written may not be closed; write it instead.
      if (op.opcode == OP_CLOSE && slot_live[op.idx] && !gid_known[op.idx])
        op.opcode = OP_SET;
      send_table_op(op);
      if (op.opcode != OP_UNUSED) begin
        done++;
        stretch--;
      end
    end
  endtask

  initial begin
    slot_live      = '0;
    gid_known      = '0;
    live_total     = 0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_gid[i]    = '0;
      slot_flags[i]  = '0;
      slot_offset[i] = '0;
    end
    set_idling(33, 73);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_opcode();
    test_inactive_slot();
    test_fill_to_full();
    test_set_and_close();
    test_random_traffic(400);
    set_idling(73, 33);
    test_random_traffic(400);
    set_idling(0, 0);
    test_random_traffic(400);

    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
